// ===== design/dsw_pkg.sv =====
// ----------------------------------------------------------------------------
// dsw_pkg: shared types and helpers for the date stepper
// Request and status codes, date record, calendar tables, constant dividers.
// ----------------------------------------------------------------------------
package dsw_pkg;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned SUM_W   = 15;

    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS   = 5'd29;
    localparam logic [DAY_W-1:0]   DEC_DAYS        = 5'd31;

    // floor(y / 100) for y < 43699 as (y * 5243) >> 19
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    // floor(s / 7) for s < 43690 as (s * 18725) >> 17
    localparam logic [14:0] DIV7_MUL   = 15'd18725;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [2:0] MONTH_OFF [12] = '{
        3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
        3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
    };

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_BACK = 2'd1,
        REQ_FWD  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_NO_DATE = 2'd3
    } status_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               have;
    } date_t;

    typedef struct packed {
        date_t   date;
        status_t status;
    } step_t;

    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
        logic [26:0] p;
        begin
            p = 27'(y) * 27'(DIV100_MUL);
            return p[26:19];
        end
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [7:0]        q;
        logic [YEAR_W-1:0] r100;
        begin
            q    = div100(y);
            r100 = y - (14'(q) * 14'd100);
            // divisible by 400 means divisible by 100 with a quotient divisible by 4
            return ((y[1:0] == 2'b00) && (r100 != '0)) ||
                   ((r100 == '0) && (q[1:0] == 2'b00));
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            if ((m == '0) || (m > MONTHS_PER_YEAR))
                len = '0;
            else if ((m == 4'd2) && leap)
                len = LEAP_FEB_DAYS;
            else
                len = MONTH_LEN[4'(m - 4'd1)];
            return len;
        end
    endfunction

    // sakamoto sum before the mod 7
    function automatic logic [SUM_W-1:0] weekday_sum(input date_t d);
        logic [YEAR_W-1:0] y;
        logic [7:0]        q100;
        logic [2:0]        off;
        begin
            y    = (d.month < 4'd3) ? (d.year - 14'd1) : d.year;
            q100 = div100(y);
            off  = ((d.month == '0) || (d.month > MONTHS_PER_YEAR)) ? 3'd0
                   : MONTH_OFF[4'(d.month - 4'd1)];
            return 15'(y) + 15'(y[YEAR_W-1:2]) - 15'(q100) + 15'(q100[7:2])
                   + 15'(off) + 15'(d.day);
        end
    endfunction

    function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] s);
        logic [29:0]      p;
        logic [12:0]      q;
        logic [SUM_W-1:0] r;
        begin
            p = 30'(s) * 30'(DIV7_MUL);
            q = p[29:17];
            r = s - (15'(q) * 15'd7);
            return r[WDAY_W-1:0];
        end
    endfunction

endpackage

// ===== design/dsw_step.sv =====
// ----------------------------------------------------------------------------
// dsw_step: next-date logic
// Checks a load, or moves the held date one day back or forward with the
// leap rule, and gives the new date with a status code.
// ----------------------------------------------------------------------------
module dsw_step #(
    parameter int unsigned MAX_YEAR = dsw_pkg::MAX_YEAR_DEF
) (
    input  dsw_pkg::req_t   req,
    input  logic [13:0]     load_year,
    input  logic [3:0]      load_month,
    input  logic [4:0]      load_day,
    input  dsw_pkg::date_t  cur,
    output dsw_pkg::step_t  nxt
);

    localparam logic [13:0] YEAR_MAX = 14'(MAX_YEAR);

    logic       ld_leap;
    logic [4:0] ld_len;
    logic       ld_ok;
    logic       cur_leap;
    logic [4:0] cur_len;
    logic [4:0] prev_len;

    assign ld_leap  = dsw_pkg::is_leap(load_year);
    assign ld_len   = dsw_pkg::month_days(load_month, ld_leap);
    assign ld_ok    = (load_year != '0) && (load_year <= YEAR_MAX) &&
                      (load_day != '0) && (load_day <= ld_len);
    assign cur_leap = dsw_pkg::is_leap(cur.year);
    assign cur_len  = dsw_pkg::month_days(cur.month, cur_leap);
    assign prev_len = dsw_pkg::month_days(4'(cur.month - 4'd1), cur_leap);

    always_comb
    begin
        nxt.date   = cur;
        nxt.status = dsw_pkg::ST_OK;
        if (req == dsw_pkg::REQ_LOAD)
        begin
            if (ld_ok)
            begin
                nxt.date.year  = load_year;
                nxt.date.month = load_month;
                nxt.date.day   = load_day;
                nxt.date.have  = 1'b1;
            end
            else
            begin
                nxt.status = dsw_pkg::ST_REJECT;
            end
        end
        else if (!cur.have)
        begin
            nxt.status = dsw_pkg::ST_NO_DATE;
        end
        else
        begin
            case (req)
                dsw_pkg::REQ_BACK:
                begin
                    if (cur.day > 5'd1)
                        nxt.date.day = cur.day - 5'd1;
                    else if (cur.month > 4'd1)
                    begin
                        nxt.date.month = cur.month - 4'd1;
                        nxt.date.day   = prev_len;
                    end
                    else if (cur.year > 14'd1)
                    begin
                        nxt.date.year  = cur.year - 14'd1;
                        nxt.date.month = dsw_pkg::MONTHS_PER_YEAR;
                        nxt.date.day   = dsw_pkg::DEC_DAYS;
                    end
                    else
                        nxt.status = dsw_pkg::ST_LIMIT;
                end
                dsw_pkg::REQ_FWD:
                begin
                    if (cur.day < cur_len)
                        nxt.date.day = cur.day + 5'd1;
                    else if (cur.month < dsw_pkg::MONTHS_PER_YEAR)
                    begin
                        nxt.date.month = cur.month + 4'd1;
                        nxt.date.day   = 5'd1;
                    end
                    else if (cur.year < YEAR_MAX)
                    begin
                        nxt.date.year  = cur.year + 14'd1;
                        nxt.date.month = 4'd1;
                        nxt.date.day   = 5'd1;
                    end
                    else
                        nxt.status = dsw_pkg::ST_LIMIT;
                end
                default:
                begin
                    // unused request code leaves the date alone
                end
            endcase
        end
    end

endmodule

// ===== design/date_stepper_with_weekday.sv =====
// ----------------------------------------------------------------------------
// date_stepper_with_weekday: Gregorian date counter with weekday output
// Throughput: one item per cycle unless m_axis_tready stalls the output;
// the held date updates at accept, and the weekday follows in two pipeline
// stages (constant-multiply divide, mod 7) after the s1 register.
// Reset: asynchronous, clears the held date and empties all pipeline stages.
// ----------------------------------------------------------------------------
module date_stepper_with_weekday #(
    parameter int unsigned MAX_YEAR = dsw_pkg::MAX_YEAR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // load_year, load_month, load_day, pad
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // year, month, day, weekday, pad
    output logic [2:0]  m_axis_tuser    // date_valid, status
);

    dsw_pkg::date_t  cur_reg;
    dsw_pkg::step_t  step;

    logic            s1_valid_reg;
    dsw_pkg::step_t  s1_reg;
    logic            s2_valid_reg;
    dsw_pkg::step_t  s2_reg;
    logic [14:0]     s2_sum_reg;
    logic            out_valid_reg;
    dsw_pkg::step_t  out_reg;
    logic [2:0]      out_wday_reg;

    logic            out_ready;
    logic            s2_ready;
    logic            s1_ready;
    logic            accept;
    logic [14:0]     s2_sum_next;
    logic [2:0]      out_wday_next;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign accept        = s_axis_tvalid && s1_ready;

    dsw_step #(
        .MAX_YEAR (MAX_YEAR)
    ) u_step (
        .req        (dsw_pkg::req_t'(s_axis_tuser)),
        .load_year  (s_axis_tdata[13:0]),
        .load_month (s_axis_tdata[17:14]),
        .load_day   (s_axis_tdata[22:18]),
        .cur        (cur_reg),
        .nxt        (step)
    );

    // no held date gives a zero sum, so the weekday field reads zero
    assign s2_sum_next   = s1_reg.date.have ? dsw_pkg::weekday_sum(s1_reg.date) : '0;
    assign out_wday_next = dsw_pkg::mod7(s2_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                cur_reg <= step.date;
            if (s1_ready)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= step;
        if (s2_ready)
        begin
            s2_reg     <= s1_reg;
            s2_sum_reg <= s2_sum_next;
        end
        if (out_ready)
        begin
            out_reg      <= s2_reg;
            out_wday_reg <= out_wday_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_wday_reg, out_reg.date.day,
                            out_reg.date.month, out_reg.date.year};
    assign m_axis_tuser  = {out_reg.status, out_reg.date.have};

`ifndef SYNTHESIS
    // a held date is never dropped
    a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(cur_reg.have))
        else $error("held date lost");

    // no held date means an all-zero date on the output
    a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[25:0] == 26'd0)
        else $error("date shown without a held date");

    // refused step only occurs with no held date
    a_no_date_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:1] == dsw_pkg::ST_NO_DATE) |-> !m_axis_tuser[0])
        else $error("no-date status with a held date");

    // a stalled first stage keeps its contents
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("stage one changed while stalled");

    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[25:23] != 3'd7)
        else $error("weekday out of range");
`endif

endmodule
